### sv/hbd_pkg.sv
// Shared types, constants and the CRC byte update for the HDLC bit deframer.
`default_nettype none
package hbd_pkg;

  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned POS_W     = $clog2(BYTE_BITS);

  localparam logic [BYTE_BITS-1:0] FLAG_VALUE   = 8'h7E;
  localparam logic [2:0]           STUFF_RUN    = 3'd5;
  localparam logic [2:0]           ABORT_RUN    = 3'd7;
  localparam logic [POS_W-1:0]     LAST_POS     = POS_W'(BYTE_BITS - 1);
  localparam logic [15:0]          FCS_BYTES    = 16'd2;
  localparam logic [1:0]           HOLD_FULL    = 2'd2;
  localparam logic [15:0]          CRC_INIT     = 16'hFFFF;
  localparam logic [15:0]          CRC_POLY     = 16'h8408;
  localparam logic [15:0]          MAX_FRAME_RST = 16'd4096;

  localparam logic [1:0] EV_BYTE  = 2'd0;
  localparam logic [1:0] EV_END   = 2'd1;
  localparam logic [1:0] EV_ABORT = 2'd2;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic [1:0]           code;
    logic [BYTE_BITS-1:0] data;
    logic                 aligned;
  } hbd_event_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {8'd0, data};
    for (int k = 0; k < 8; k++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage
`default_nettype wire

### sv/hbd_front.sv
// Bit-level front end: flag search, abort detect, zero removal and byte packing.
`default_nettype none
module hbd_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_line_bit,
  output logic                    in_stall,
  input  wire logic               q_full,
  output logic                    push,
  output hbd_pkg::hbd_event_t     push_ev
);
  import hbd_pkg::*;

  logic [BYTE_BITS-1:0] recent_r, recent_nxt;
  logic [2:0]           ones_r, ones_nxt;
  logic                 in_frame_r, in_frame_nxt;
  logic [BYTE_BITS-1:0] shift_r, shift_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic                 accept;
  logic [BYTE_BITS-1:0] packed_bits;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    recent_nxt   = recent_r;
    ones_nxt     = ones_r;
    in_frame_nxt = in_frame_r;
    shift_nxt    = shift_r;
    pos_nxt      = pos_r;
    push         = 1'b0;
    push_ev      = '0;
    packed_bits  = shift_r | (BYTE_BITS'(in_line_bit) << pos_r);
    if (accept) begin
      recent_nxt = {in_line_bit, recent_r[BYTE_BITS-1:1]};
      if (!in_line_bit) begin
        ones_nxt = 3'd0;
      end else if (ones_r != ABORT_RUN) begin
        ones_nxt = ones_r + 3'd1;
      end
      priority if (recent_nxt == FLAG_VALUE) begin
        push            = in_frame_r;
        push_ev.code    = EV_END;
        push_ev.aligned = (pos_r == LAST_POS);
        in_frame_nxt    = 1'b1;
        shift_nxt       = '0;
        pos_nxt         = '0;
      end else if (ones_nxt == ABORT_RUN) begin
        push         = in_frame_r;
        push_ev.code = EV_ABORT;
        in_frame_nxt = 1'b0;
        shift_nxt    = '0;
        pos_nxt      = '0;
      end else if (in_frame_r && !(!in_line_bit && ones_r == STUFF_RUN)) begin
        if (pos_r == LAST_POS) begin
          push         = 1'b1;
          push_ev.code = EV_BYTE;
          push_ev.data = packed_bits;
          shift_nxt    = '0;
          pos_nxt      = '0;
        end else begin
          shift_nxt = packed_bits;
          pos_nxt   = pos_r + POS_W'(1);
        end
      end else begin
        in_frame_nxt = in_frame_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recent_r   <= '0;
      ones_r     <= '0;
      in_frame_r <= 1'b0;
      shift_r    <= '0;
      pos_r      <= '0;
    end else begin
      recent_r   <= recent_nxt;
      ones_r     <= ones_nxt;
      in_frame_r <= in_frame_nxt;
      shift_r    <= shift_nxt;
      pos_r      <= pos_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/hbd_queue.sv
// Two-entry event queue between the bit front end and the frame back end.
`default_nettype none
module hbd_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire hbd_pkg::hbd_event_t push_ev,
  output logic                    full,
  input  wire logic               pop,
  output logic                    pop_valid,
  output hbd_pkg::hbd_event_t     pop_ev
);
  import hbd_pkg::*;

  hbd_event_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_pop;

  assign full      = (count_r == 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign pop_ev    = entry_r[rd_ptr_r];
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

### sv/hbd_back.sv
// Frame back end: FCS hold, CRC, length checks, frame counters and result register.
`default_nettype none
module hbd_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [15:0]        cfg_wr_data,
  input  wire logic               ev_valid,
  input  wire hbd_pkg::hbd_event_t ev,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_kind,
  output logic [7:0]              out_data_byte,
  output logic                    out_crc_ok,
  output logic                    out_length_error,
  output logic [31:0]             out_good_frames,
  output logic [31:0]             out_bad_frames
);
  import hbd_pkg::*;

  logic [15:0] max_frame_r;
  logic [7:0]  held0_r, held0_nxt, held1_r, held1_nxt;
  logic [1:0]  held_cnt_r, held_cnt_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] len_r, len_nxt;
  logic        too_long_r, too_long_nxt;
  logic [31:0] good_r, good_nxt, bad_r, bad_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        kind_r, kind_nxt, ok_r, ok_nxt, lerr_r, lerr_nxt;
  logic [7:0]  data_r, data_nxt;
  logic        emit, lerr_c, ok_c;

  assign pop = ev_valid && (!out_valid_r || !out_stall);

  always_comb begin
    held0_nxt    = held0_r;
    held1_nxt    = held1_r;
    held_cnt_nxt = held_cnt_r;
    crc_nxt      = crc_r;
    len_nxt      = len_r;
    too_long_nxt = too_long_r;
    good_nxt     = good_r;
    bad_nxt      = bad_r;
    kind_nxt     = KIND_DATA;
    data_nxt     = '0;
    ok_nxt       = 1'b0;
    lerr_nxt     = 1'b0;
    emit         = 1'b0;
    lerr_c       = (len_r < FCS_BYTES) || too_long_r || !ev.aligned;
    ok_c         = (held_cnt_r == HOLD_FULL) && ((~crc_r) == {held1_r, held0_r});
    if (pop) begin
      unique case (ev.code)
        EV_BYTE: begin
          if (len_r >= max_frame_r) begin
            too_long_nxt = 1'b1;
          end
          if (len_r != 16'hFFFF) begin
            len_nxt = len_r + 16'd1;
          end
          if (held_cnt_r == HOLD_FULL) begin
            crc_nxt   = crc_byte(crc_r, held0_r);
            held0_nxt = held1_r;
            held1_nxt = ev.data;
            data_nxt  = held0_r;
            emit      = 1'b1;
          end else begin
            if (held_cnt_r[0]) begin
              held1_nxt = ev.data;
            end else begin
              held0_nxt = ev.data;
            end
            held_cnt_nxt = held_cnt_r + 2'd1;
          end
        end
        EV_END: begin
          if (len_r != 16'd0) begin
            emit     = 1'b1;
            kind_nxt = KIND_END;
            ok_nxt   = ok_c;
            lerr_nxt = lerr_c;
            if (ok_c && !lerr_c) begin
              if (good_r != 32'hFFFF_FFFF) begin
                good_nxt = good_r + 32'd1;
              end
            end else if (bad_r != 32'hFFFF_FFFF) begin
              bad_nxt = bad_r + 32'd1;
            end
          end
          held_cnt_nxt = '0;
          crc_nxt      = CRC_INIT;
          len_nxt      = '0;
          too_long_nxt = 1'b0;
        end
        EV_ABORT: begin
          held_cnt_nxt = '0;
          crc_nxt      = CRC_INIT;
          len_nxt      = '0;
          too_long_nxt = 1'b0;
        end
        default: begin
          held_cnt_nxt = held_cnt_r;
        end
      endcase
    end
    if (pop) begin
      out_valid_nxt = emit;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      held0_r <= held0_nxt;
      held1_r <= held1_nxt;
    end
    if (pop && emit) begin
      kind_r <= kind_nxt;
      data_r <= data_nxt;
      ok_r   <= ok_nxt;
      lerr_r <= lerr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_frame_r <= MAX_FRAME_RST;
      held_cnt_r  <= '0;
      crc_r       <= CRC_INIT;
      len_r       <= '0;
      too_long_r  <= 1'b0;
      good_r      <= '0;
      bad_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_frame_r <= cfg_wr_data;
      end
      held_cnt_r  <= held_cnt_nxt;
      crc_r       <= crc_nxt;
      len_r       <= len_nxt;
      too_long_r  <= too_long_nxt;
      good_r      <= good_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = kind_r;
  assign out_data_byte    = data_r;
  assign out_crc_ok       = ok_r;
  assign out_length_error = lerr_r;
  assign out_good_frames  = good_r;
  assign out_bad_frames   = bad_r;

endmodule
`default_nettype wire

### sv/hdlc_bit_deframer_crc16.sv
// Top level of the HDLC bit deframer with CRC-16/X.25 check.
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_stall   | in_line_bit
//  out_    | output    | out_valid / out_stall | kind, data_byte, crc_ok, length_error,
//          |           |                       | good_frames, bad_frames
//  cfg_    | input     | cfg_wr_en             | cfg_wr_data (max_frame_bytes)
//
// One line bit is taken per cycle while in_stall is low; the event that completes a
// result is registered in the queue, and the back end then loads the output register.
// The two-entry event queue sets the slack: in_stall rises only when it is full.
// Reset is synchronous; it clears the flag search, counters and output valid,
// and max_frame_bytes returns to 4096.
`default_nettype none
module hdlc_bit_deframer_crc16 (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_line_bit,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_kind,
  output logic [7:0]       out_data_byte,
  output logic             out_crc_ok,
  output logic             out_length_error,
  output logic [31:0]      out_good_frames,
  output logic [31:0]      out_bad_frames
);
  import hbd_pkg::*;

  hbd_event_t push_ev, pop_ev;
  logic       push, q_full, pop, pop_valid;

  hbd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_line_bit (in_line_bit),
    .in_stall    (in_stall),
    .q_full      (q_full),
    .push        (push),
    .push_ev     (push_ev)
  );

  hbd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_ev   (push_ev),
    .full      (q_full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_ev    (pop_ev)
  );

  hbd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .ev_valid         (pop_valid),
    .ev               (pop_ev),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_data_byte    (out_data_byte),
    .out_crc_ok       (out_crc_ok),
    .out_length_error (out_length_error),
    .out_good_frames  (out_good_frames),
    .out_bad_frames   (out_bad_frames)
  );

endmodule
`default_nettype wire

### sv/hbd_checker.sv
// Port-level assertions for the HDLC bit deframer and their bind.
`default_nettype none
module hbd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_kind,
  input wire logic [7:0]  out_data_byte,
  input wire logic        out_crc_ok,
  input wire logic        out_length_error,
  input wire logic [31:0] out_good_frames,
  input wire logic [31:0] out_bad_frames
);
  import hbd_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) &&
      $stable(out_data_byte) && $stable(out_good_frames) && $stable(out_bad_frames))
    else $error("stalled result changed");

  a_item_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_DATA && !out_crc_ok && !out_length_error) ||
                  (out_kind == KIND_END && out_data_byte == 8'd0))
    else $error("result fields inconsistent with kind");

  a_counts_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && out_valid && $past(out_valid) |->
      out_good_frames >= $past(out_good_frames) &&
      out_bad_frames >= $past(out_bad_frames))
    else $error("frame counters decreased");

endmodule

bind hdlc_bit_deframer_crc16 hbd_checker u_hbd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_kind         (out_kind),
  .out_data_byte    (out_data_byte),
  .out_crc_ok       (out_crc_ok),
  .out_length_error (out_length_error),
  .out_good_frames  (out_good_frames),
  .out_bad_frames   (out_bad_frames)
);
`default_nettype wire
